[rtl/core/f2d_pkg.sv]
// shared constants and types of the two-dimensional fenwick range-sum block
package f2d_pkg;

  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_COLS = 64;

  // request field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IDX_W = 1;

  // node index widths: a count up to the size, one more bit for the upward walk
  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  localparam int unsigned COL_W  = $clog2(MAX_COLS);
  localparam int unsigned RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCNT_W = $clog2(MAX_COLS + 1);
  localparam int unsigned RIDX_W = RCNT_W + 1;
  localparam int unsigned CIDX_W = CCNT_W + 1;

  // node store, row-major with a power-of-two row pitch
  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W = ROW_W + COL_W;

  localparam int unsigned IN_DATA_W  = 4 * COORD_W + VAL_W;
  localparam int unsigned OUT_DATA_W = SUM_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 2'd0,
    REQ_SET  = 2'd1,
    REQ_RECT = 2'd2,
    REQ_CELL = 2'd3
  } req_e;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

  // command to the index walker
  typedef struct packed {
    logic               start;
    logic               up;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } walk_cmd_t;

  // one node address per cycle from the walker
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } walk_out_t;

endpackage

[rtl/core/f2d_ram.sv]
// single-port-write, single-port-read node store with registered read data
module f2d_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/core/f2d_alu.sv]
// shared 48-bit add/subtract unit for prefix accumulation, node update and set delta
module f2d_alu (
  input  logic [f2d_pkg::SUM_W-1:0] a_i,
  input  logic [f2d_pkg::SUM_W-1:0] b_i,
  input  logic                      sub_i,
  output logic [f2d_pkg::SUM_W-1:0] y_o
);
  import f2d_pkg::*;

  logic [SUM_W-1:0] b_op;

  // two's complement subtract through inverted operand and carry in
  assign b_op = sub_i ? ~b_i : b_i;
  assign y_o  = a_i + b_op + SUM_W'(sub_i);

endmodule

[rtl/core/f2d_walk.sv]
// fenwick index walker: steps (i, j) down for prefix sums or up for node updates
module f2d_walk (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  f2d_pkg::walk_cmd_t         cmd_i,
  input  logic [f2d_pkg::RCNT_W-1:0] rows_i,
  input  logic [f2d_pkg::CCNT_W-1:0] cols_i,
  output f2d_pkg::walk_out_t         walk_o
);
  import f2d_pkg::*;

  logic              busy_q, busy_d;
  logic              up_q, up_d;
  logic [RIDX_W-1:0] i_q, i_d;
  logic [CIDX_W-1:0] j_q, j_d;
  logic [CIDX_W-1:0] j0_q, j0_d;

  logic [RIDX_W-1:0] lb_i, i_nxt, i_m1;
  logic [CIDX_W-1:0] lb_j, j_nxt, j_m1;
  logic              i_done, j_done;

  always_comb begin
    lb_i  = i_q & (~i_q + RIDX_W'(1));
    lb_j  = j_q & (~j_q + CIDX_W'(1));
    i_nxt = up_q ? (i_q + lb_i) : (i_q - lb_i);
    j_nxt = up_q ? (j_q + lb_j) : (j_q - lb_j);
    i_done = up_q ? (i_nxt > RIDX_W'(rows_i)) : (i_nxt == '0);
    j_done = up_q ? (j_nxt > CIDX_W'(cols_i)) : (j_nxt == '0);
    i_m1  = i_q - RIDX_W'(1);
    j_m1  = j_q - CIDX_W'(1);
  end

  assign walk_o.valid = busy_q;
  assign walk_o.last  = busy_q & i_done & j_done;
  assign walk_o.addr  = {i_m1[ROW_W-1:0], j_m1[COL_W-1:0]};

  always_comb begin
    busy_d = busy_q;
    up_d   = up_q;
    i_d    = i_q;
    j_d    = j_q;
    j0_d   = j0_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      up_d   = cmd_i.up;
      i_d    = RIDX_W'(cmd_i.row) + RIDX_W'(1);
      j_d    = CIDX_W'(cmd_i.col) + CIDX_W'(1);
      j0_d   = CIDX_W'(cmd_i.col) + CIDX_W'(1);
    end else if (busy_q) begin
      if (j_done) begin
        // row of the walk finished, move to the next row node
        j_d = j0_q;
        i_d = i_nxt;
        if (i_done) begin
          busy_d = 1'b0;
        end
      end else begin
        j_d = j_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q <= up_d;
    i_q  <= i_d;
    j_q  <= j_d;
    j0_q <= j0_d;
  end

endmodule

[rtl/core/fenwick_2d_range_sum.sv]
// top level of the two-dimensional fenwick range-sum block: sequencer, node store and datapath
//
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: row_a col_a row_b col_b value
//                                                    tuser: req_type
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: sum, tuser: status
// cfg       in         cfg_we_i (no wait)            cfg_idx_i, cfg_wdata_i
//
// one node read per cycle through the shared memory read port and the single adder
// rectangle or cell query: reads of up to four prefix sums, at most 36 node reads each
// add: up to 49 node updates; set: a cell query then the update
// an out-of-range request goes from acceptance straight to the output state, which then registers its error status
// reset and every size write start a clearing pass over the whole node store, no request taken meanwhile
// a result held by m_axis_tready low stalls the next result, not the next acceptance
module fenwick_2d_range_sum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // row_a, col_a, row_b, col_b, value
  input  logic [f2d_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [f2d_pkg::REQ_W-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // sum
  output logic [f2d_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic                           m_axis_tuser,
  input  logic                           cfg_we_i,
  input  logic [f2d_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [f2d_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import f2d_pkg::*;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_LAUNCH = 9'b000000100,
    ST_PREFIX = 9'b000001000,
    ST_PDRAIN = 9'b000010000,
    ST_DELTA  = 9'b000100000,
    ST_UPDATE = 9'b001000000,
    ST_UDRAIN = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [RCNT_W-1:0]  rows_q, rows_d;
  logic [CCNT_W-1:0]  cols_q, cols_d;

  req_e               op_q, op_d;
  logic [COORD_W-1:0] ra_q, ra_d, ca_q, ca_d, rb_q, rb_d, cb_q, cb_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic               bad_q, bad_d;
  logic               zero_q, zero_d;
  logic [1:0]         term_q, term_d;
  logic [3:0]         en_q, en_d;
  logic [SUM_W-1:0]   acc_q, acc_d;
  logic [SUM_W-1:0]   delta_q, delta_d;

  logic               rd_vld_q, rd_neg_q, rd_upd_q;
  logic [ADDR_W-1:0]  wr_addr_q;

  logic               m_valid_q, m_valid_d;
  logic [SUM_W-1:0]   m_sum_q, m_sum_d;
  logic               m_status_q, m_status_d;

  walk_cmd_t          walk_cmd;
  walk_out_t          walk;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [SUM_W-1:0]   mem_wdata;
  logic [SUM_W-1:0]   rd_data;

  logic [SUM_W-1:0]   alu_a, alu_b, alu_y;
  logic               alu_sub;
  logic [SUM_W-1:0]   val_ext;

  logic               in_acc;
  req_e               in_op;
  logic [COORD_W-1:0] in_ra, in_ca, in_rb, in_cb;
  logic               in_bad;

  logic [1:0]         next_term;
  logic               has_next;
  logic [1:0]         start_term;

  function automatic logic [RCNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [RCNT_W-1:0] r;
    if (v == '0) begin
      r = RCNT_W'(1);
    end else if (int'(v) > int'(MAX_ROWS)) begin
      r = RCNT_W'(MAX_ROWS);
    end else begin
      r = RCNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [CCNT_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    logic [CCNT_W-1:0] r;
    if (v == '0) begin
      r = CCNT_W'(1);
    end else if (int'(v) > int'(MAX_COLS)) begin
      r = CCNT_W'(MAX_COLS);
    end else begin
      r = CCNT_W'(v);
    end
    return r;
  endfunction

  assign in_op = req_e'(s_axis_tuser);
  assign in_ra = s_axis_tdata[COORD_W-1:0];
  assign in_ca = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign in_rb = s_axis_tdata[3*COORD_W-1:2*COORD_W];
  assign in_cb = s_axis_tdata[4*COORD_W-1:3*COORD_W];

  always_comb begin
    in_bad = (RCNT_W'(in_ra) >= rows_q) || (CCNT_W'(in_ca) >= cols_q);
    if (in_op == REQ_RECT) begin
      in_bad = in_bad || (RCNT_W'(in_rb) >= rows_q) || (CCNT_W'(in_cb) >= cols_q);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign val_ext       = {{(SUM_W-VAL_W){val_q[VAL_W-1]}}, val_q};

  // next enabled inclusion-exclusion term after the current one
  always_comb begin
    next_term = term_q;
    has_next  = 1'b0;
    for (int k = 3; k >= 1; k--) begin
      if ((2'(k) > term_q) && en_q[k]) begin
        next_term = 2'(k);
        has_next  = 1'b1;
      end
    end
  end

  // term bit 0 moves the row above the rectangle, bit 1 the column left of it
  always_comb begin
    start_term   = (state_q == ST_LAUNCH) ? 2'd0 : next_term;
    walk_cmd     = '0;
    walk_cmd.row = start_term[0] ? (ra_q - COORD_W'(1)) : rb_q;
    walk_cmd.col = start_term[1] ? (ca_q - COORD_W'(1)) : cb_q;
    case (state_q)
      ST_LAUNCH: begin
        walk_cmd.start = 1'b1;
        if (op_q == REQ_ADD) begin
          walk_cmd.up  = 1'b1;
          walk_cmd.row = ra_q;
          walk_cmd.col = ca_q;
        end
      end
      ST_PREFIX: begin
        walk_cmd.start = walk.last & has_next;
      end
      ST_DELTA: begin
        walk_cmd.start = 1'b1;
        walk_cmd.up    = 1'b1;
        walk_cmd.row   = ra_q;
        walk_cmd.col   = ca_q;
      end
      default: begin
        walk_cmd.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (state_q == ST_DELTA) begin
      alu_a   = val_ext;
      alu_b   = acc_q;
      alu_sub = 1'b1;
    end else if (rd_upd_q) begin
      alu_a   = delta_q;
      alu_b   = rd_data;
      alu_sub = 1'b0;
    end else begin
      alu_a   = acc_q;
      alu_b   = rd_data;
      alu_sub = rd_neg_q;
    end
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = rd_vld_q & rd_upd_q;
      mem_waddr = wr_addr_q;
      mem_wdata = alu_y;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    rows_d     = rows_q;
    cols_d     = cols_q;
    op_d       = op_q;
    ra_d       = ra_q;
    ca_d       = ca_q;
    rb_d       = rb_q;
    cb_d       = cb_q;
    val_d      = val_q;
    bad_d      = bad_q;
    zero_d     = zero_q;
    term_d     = term_q;
    en_d       = en_q;
    acc_d      = acc_q;
    delta_d    = delta_q;
    m_valid_d  = m_valid_q & ~m_axis_tready;
    m_sum_d    = m_sum_q;
    m_status_d = m_status_q;

    if (rd_vld_q && !rd_upd_q) begin
      acc_d = alu_y;
    end

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_d   = in_op;
          ra_d   = in_ra;
          ca_d   = in_ca;
          val_d  = s_axis_tdata[IN_DATA_W-1:4*COORD_W];
          bad_d  = in_bad;
          zero_d = in_bad || (in_op == REQ_ADD) || (in_op == REQ_SET);
          acc_d  = '0;
          if (in_op == REQ_RECT) begin
            rb_d = in_rb;
            cb_d = in_cb;
          end else begin
            rb_d = in_ra;
            cb_d = in_ca;
          end
          en_d    = {(in_ra != '0) && (in_ca != '0), in_ca != '0, in_ra != '0, 1'b1};
          state_d = in_bad ? ST_OUT : ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        term_d = 2'd0;
        if (op_q == REQ_ADD) begin
          delta_d = val_ext;
          state_d = ST_UPDATE;
        end else begin
          state_d = ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        if (walk.last) begin
          if (has_next) begin
            term_d = next_term;
          end else begin
            state_d = ST_PDRAIN;
          end
        end
      end
      ST_PDRAIN: begin
        state_d = (op_q == REQ_SET) ? ST_DELTA : ST_OUT;
      end
      ST_DELTA: begin
        delta_d = alu_y;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (walk.last) begin
          state_d = ST_UDRAIN;
        end
      end
      ST_UDRAIN: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_sum_d    = zero_q ? '0 : acc_q;
          m_status_d = bad_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase

    // a size write restarts the clearing pass
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS: rows_d = clamp_rows(cfg_wdata_i);
        CFG_COLS: cols_d = clamp_cols(cfg_wdata_i);
        default: begin
          rows_d = rows_q;
        end
      endcase
      state_d = ST_CLEAR;
      clr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      rows_q    <= RCNT_W'(MAX_ROWS);
      cols_q    <= CCNT_W'(MAX_COLS);
      rd_vld_q  <= 1'b0;
      rd_upd_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rows_q    <= rows_d;
      cols_q    <= cols_d;
      rd_vld_q  <= walk.valid;
      rd_upd_q  <= (state_q == ST_UPDATE);
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ra_q       <= ra_d;
    ca_q       <= ca_d;
    rb_q       <= rb_d;
    cb_q       <= cb_d;
    val_q      <= val_d;
    bad_q      <= bad_d;
    zero_q     <= zero_d;
    term_q     <= term_d;
    en_q       <= en_d;
    acc_q      <= acc_d;
    delta_q    <= delta_d;
    rd_neg_q   <= term_q[0] ^ term_q[1];
    wr_addr_q  <= walk.addr;
    m_sum_q    <= m_sum_d;
    m_status_q <= m_status_d;
  end

  f2d_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (walk_cmd),
    .rows_i (rows_q),
    .cols_i (cols_q),
    .walk_o (walk)
  );

  f2d_ram #(
    .Depth (DEPTH),
    .Width (SUM_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (walk.valid),
    .raddr_i (walk.addr),
    .rdata_o (rd_data)
  );

  f2d_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .y_o   (alu_y)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_sum_q;
  assign m_axis_tuser  = m_status_q;

`ifndef NO_ASSERTIONS
  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("node store written while idle");

  a_walk_in_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk.valid |-> ((state_q == ST_PREFIX) || (state_q == ST_UPDATE)))
    else $error("walker active outside a prefix or update phase");

  a_drained_at_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!rd_vld_q && !walk.valid))
    else $error("read still in flight when a new transaction is taken");

  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_OUT) && m_axis_tvalid && !m_axis_tready && !cfg_we_i)
      |=> (state_q == ST_OUT))
    else $error("pending result overwritten");
`endif

endmodule

[test/tb_fenwick_2d_range_sum.sv]
// self-checking testbench for the two-dimensional fenwick range-sum block
`timescale 1ns / 1ps

module tb_fenwick_2d_range_sum;
  import f2d_pkg::*;

  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  localparam int unsigned PHASES     = 10;
  localparam int unsigned PHASE_REQS = 140;
  localparam int unsigned DRAIN_CYC  = 250;

  typedef struct {
    req_e               kind;
    logic [COORD_W-1:0] row_a;
    logic [COORD_W-1:0] col_a;
    logic [COORD_W-1:0] row_b;
    logic [COORD_W-1:0] col_b;
    logic [VAL_W-1:0]   value;
  } request_t;

  typedef struct {
    logic [SUM_W-1:0] sum;
    logic             status;
  } result_t;

  typedef struct {
    bit                   is_size;
    logic [CFG_IDX_W-1:0] size_idx;
    logic [CFG_W-1:0]     size_val;
    request_t             rq;
    bit                   typed;
    result_t              want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [REQ_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  // predictor state
  logic [SUM_W-1:0] node_sum [MAX_ROWS*MAX_COLS];
  int unsigned grid_rows;
  int unsigned grid_cols;

  result_t pending_results [$];
  dir_row_t dir_rows [$];
  int unsigned mismatches = 0;
  bit steady_flow = 1'b0;

  fenwick_2d_range_sum u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("fenwick_2d_range_sum verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_grid();
    foreach (node_sum[k]) node_sum[k] = '0;
  endfunction

  function automatic void node_add(int unsigned r, int unsigned c, logic [SUM_W-1:0] delta);
    int unsigned i;
    int unsigned j;
    for (i = r + 1; i <= grid_rows; i += i & (~i + 1)) begin
      for (j = c + 1; j <= grid_cols; j += j & (~j + 1)) begin
        node_sum[(i - 1) * MAX_COLS + (j - 1)] += delta;
      end
    end
  endfunction

  function automatic logic [SUM_W-1:0] prefix_sum(int unsigned r, int unsigned c);
    logic [SUM_W-1:0] s;
    int unsigned i;
    int unsigned j;
    s = '0;
    for (i = r + 1; i > 0; i -= i & (~i + 1)) begin
      for (j = c + 1; j > 0; j -= j & (~j + 1)) begin
        s += node_sum[(i - 1) * MAX_COLS + (j - 1)];
      end
    end
    return s;
  endfunction

  // inclusion-exclusion, applied as is to reversed corners too
  function automatic logic [SUM_W-1:0] rect_sum(int unsigned r1, int unsigned c1,
                                                int unsigned r2, int unsigned c2);
    logic [SUM_W-1:0] s;
    s = prefix_sum(r2, c2);
    if (r1 > 0) s -= prefix_sum(r1 - 1, c2);
    if (c1 > 0) s -= prefix_sum(r2, c1 - 1);
    if (r1 > 0 && c1 > 0) s += prefix_sum(r1 - 1, c1 - 1);
    return s;
  endfunction

  function automatic result_t predict_request(request_t rq);
    result_t res;
    logic [SUM_W-1:0] delta;
    bit bad;
    res.sum = '0;
    delta = {{(SUM_W-VAL_W){rq.value[VAL_W-1]}}, rq.value};
    bad = (rq.row_a >= grid_rows) || (rq.col_a >= grid_cols);
    if (rq.kind == REQ_RECT) bad = bad || (rq.row_b >= grid_rows) || (rq.col_b >= grid_cols);
    if (!bad) begin
      case (rq.kind)
        REQ_ADD:  node_add(rq.row_a, rq.col_a, delta);
        REQ_SET:  node_add(rq.row_a, rq.col_a,
                           delta - rect_sum(rq.row_a, rq.col_a, rq.row_a, rq.col_a));
        REQ_RECT: res.sum = rect_sum(rq.row_a, rq.col_a, rq.row_b, rq.col_b);
        default:  res.sum = rect_sum(rq.row_a, rq.col_a, rq.row_a, rq.col_a);
      endcase
    end
    res.status = bad ? ST_RANGE : ST_DONE;
    return res;
  endfunction

  function automatic int unsigned clamp_size(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_ROWS) return MAX_ROWS;
    return int'(v);
  endfunction

  function automatic void dir_req(req_e k, int ra, int ca, int rb, int cb, logic [VAL_W-1:0] v,
                                  bit typed, logic [SUM_W-1:0] wsum, logic wst);
    dir_row_t row;
    row.is_size = 1'b0;
    row.size_idx = '0;
    row.size_val = '0;
    row.rq.kind = k;
    row.rq.row_a = COORD_W'(ra);
    row.rq.col_a = COORD_W'(ca);
    row.rq.row_b = COORD_W'(rb);
    row.rq.col_b = COORD_W'(cb);
    row.rq.value = v;
    row.typed = typed;
    row.want.sum = wsum;
    row.want.status = wst;
    dir_rows.push_back(row);
  endfunction

  function automatic void dir_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    dir_row_t row;
    row.is_size = 1'b1;
    row.size_idx = idx;
    row.size_val = v;
    row.rq.kind = REQ_ADD;
    row.rq.row_a = '0;
    row.rq.col_a = '0;
    row.rq.row_b = '0;
    row.rq.col_b = '0;
    row.rq.value = '0;
    row.typed = 1'b0;
    row.want.sum = '0;
    row.want.status = ST_DONE;
    dir_rows.push_back(row);
  endfunction

  // only written once every result is back, so the block is idle
  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ROWS) grid_rows = clamp_size(v);
    else grid_cols = clamp_size(v);
    clear_grid();
  endtask

  task automatic send_request(input request_t rq, input bit typed, input result_t want);
    result_t pred;
    while (!steady_flow && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rq.value, rq.col_b, rq.row_b, rq.col_a, rq.row_a};
    s_axis_tuser <= rq.kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_request(rq);
    pending_results.push_back(typed ? want : pred);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(int unsigned lim);
    if ($urandom_range(0, 99) < 88) return COORD_W'($urandom_range(0, lim - 1));
    return COORD_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'($urandom_range(65, 127));
      2, 3, 4: return CFG_W'($urandom_range(1, 8));
      default: return CFG_W'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic request_t random_request();
    request_t rq;
    logic [COORD_W-1:0] t;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) rq.kind = REQ_ADD;
    else if (pick < 5) rq.kind = REQ_SET;
    else if (pick < 8) rq.kind = REQ_RECT;
    else rq.kind = REQ_CELL;
    rq.row_a = pick_coord(grid_rows);
    rq.col_a = pick_coord(grid_cols);
    rq.row_b = pick_coord(grid_rows);
    rq.col_b = pick_coord(grid_cols);
    // mostly well-ordered rectangles, some reversed
    if (rq.kind == REQ_RECT && $urandom_range(0, 99) < 85) begin
      if (rq.row_a > rq.row_b) begin
        t = rq.row_a; rq.row_a = rq.row_b; rq.row_b = t;
      end
      if (rq.col_a > rq.col_b) begin
        t = rq.col_a; rq.col_a = rq.col_b; rq.col_b = t;
      end
    end
    case ($urandom_range(0, 9))
      0:       rq.value = 32'h7FFF_FFFF;
      1:       rq.value = 32'h8000_0000;
      2:       rq.value = '0;
      3, 4, 5: rq.value = $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: rq.value = $urandom;
    endcase
    return rq;
  endfunction

  // result side: random backpressure outside the steady phase, check each transaction in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result sum %h status %0d with nothing pending",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          result_t want;
          want = pending_results.pop_front();
          if (m_axis_tdata !== want.sum)
            report_mismatch($sformatf("sum %h, expected %h", m_axis_tdata, want.sum));
          if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser, want.status));
        end
      end
      m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 31);
    end
  end

  initial begin
    result_t no_want;
    no_want = '{default: '0};
    grid_rows = MAX_ROWS;
    grid_cols = MAX_COLS;
    clear_grid();

    // fresh store at full size
    dir_req(REQ_CELL, 0, 0, 0, 0, '0, 1, '0, ST_DONE);
    dir_req(REQ_RECT, 0, 0, 63, 63, '0, 1, '0, ST_DONE);
    dir_req(REQ_ADD, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, '0, ST_DONE);
    dir_req(REQ_ADD, 63, 63, 63, 63, 32'h8000_0000, 0, '0, ST_DONE);
    dir_req(REQ_CELL, 0, 0, 0, 0, '0, 1, 48'h0000_7FFF_FFFF, ST_DONE);
    dir_req(REQ_CELL, 63, 63, 0, 0, '0, 1, 48'hFFFF_8000_0000, ST_DONE);
    dir_req(REQ_RECT, 0, 0, 63, 63, '0, 1, 48'hFFFF_FFFF_FFFF, ST_DONE);
    dir_req(REQ_SET, 32, 17, 0, 0, 32'h0001_0000, 0, '0, ST_DONE);
    dir_req(REQ_CELL, 32, 17, 0, 0, '0, 1, 48'h0000_0001_0000, ST_DONE);
    dir_req(REQ_SET, 32, 17, 0, 0, 32'hFFFF_0000, 0, '0, ST_DONE);
    dir_req(REQ_ADD, 21, 42, 42, 21, 32'h5555_5555, 0, '0, ST_DONE);
    dir_req(REQ_ADD, 42, 21, 21, 42, 32'hAAAA_AAAA, 0, '0, ST_DONE);
    dir_req(REQ_RECT, 10, 5, 40, 50, '0, 0, '0, ST_DONE);
    // reversed corners
    dir_req(REQ_RECT, 63, 63, 0, 0, '0, 0, '0, ST_DONE);
    dir_req(REQ_RECT, 42, 42, 21, 21, '0, 0, '0, ST_DONE);
    // zero size reads as one, oversize as the maximum
    dir_size(CFG_ROWS, 7'd0);
    dir_size(CFG_COLS, 7'd127);
    dir_req(REQ_ADD, 0, 63, 0, 0, 32'h0003_0000, 0, '0, ST_DONE);
    dir_req(REQ_CELL, 1, 0, 0, 0, '0, 1, '0, ST_RANGE);
    dir_req(REQ_RECT, 0, 0, 1, 63, '0, 1, '0, ST_RANGE);
    dir_req(REQ_RECT, 0, 0, 0, 63, '0, 1, 48'h0000_0003_0000, ST_DONE);
    dir_req(REQ_SET, 0, 63, 0, 0, 32'h1234_5678, 0, '0, ST_DONE);
    dir_req(REQ_CELL, 0, 63, 0, 0, '0, 1, 48'h0000_1234_5678, ST_DONE);
    dir_size(CFG_COLS, 7'd1);
    dir_req(REQ_ADD, 0, 1, 0, 0, 32'h0000_0100, 1, '0, ST_RANGE);
    dir_req(REQ_RECT, 0, 0, 0, 1, '0, 1, '0, ST_RANGE);
    dir_size(CFG_ROWS, 7'd64);
    dir_req(REQ_CELL, 63, 0, 0, 0, '0, 1, '0, ST_DONE);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[n]) begin
      if (dir_rows[n].is_size) write_size(dir_rows[n].size_idx, dir_rows[n].size_val);
      else send_request(dir_rows[n].rq, dir_rows[n].typed, dir_rows[n].want);
    end

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_size(CFG_ROWS, 7'd64);
          write_size(CFG_COLS, 7'd64);
        end
        1: begin
          write_size(CFG_ROWS, 7'd1);
          write_size(CFG_COLS, 7'd64);
        end
        2: begin
          write_size(CFG_ROWS, 7'd64);
          write_size(CFG_COLS, 7'd1);
        end
        default: begin
          write_size(CFG_ROWS, pick_size());
          write_size(CFG_COLS, pick_size());
        end
      endcase
      // one phase runs without any idle cycles on either side
      steady_flow = (p == 4);
      for (int unsigned q = 0; q < PHASE_REQS; q++) send_request(random_request(), 0, no_want);
    end
    steady_flow = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("fenwick_2d_range_sum verification clean");
    end else begin
      $display("fenwick_2d_range_sum verification failed");
    end
    $finish;
  end

endmodule
